FILE: design/assert_macros.svh
// Assertion macros shared by the odd divisor counter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(LBL, CLK, RSTN, COND) \
  LBL: assert property (@(posedge CLK) disable iff (!(RSTN)) (COND)) \
    else $error("assertion failed: invariant violated");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(LBL, CLK, RSTN, ANTE, CONS) \
  LBL: assert property (@(posedge CLK) disable iff (!(RSTN)) (ANTE) |-> (CONS)) \
    else $error("assertion failed: same-cycle implication violated");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(LBL, CLK, RSTN, ANTE, CONS) \
  LBL: assert property (@(posedge CLK) disable iff (!(RSTN)) (ANTE) |=> (CONS)) \
    else $error("assertion failed: next-cycle implication violated");

`else

`define ASSERT_ALWAYS(LBL, CLK, RSTN, COND)
`define ASSERT_IMPLIES(LBL, CLK, RSTN, ANTE, CONS)
`define ASSERT_NEXT(LBL, CLK, RSTN, ANTE, CONS)

`endif

`endif

FILE: design/odc_pkg.sv
// Constants shared by the odd divisor counter modules.
`default_nettype none

package odc_pkg;

  // Result count width and its saturation value
  localparam int unsigned CNT_W   = 16;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Prime exponent counter: 3^41 exceeds any 64-bit value, so 7 bits hold e+1
  localparam int unsigned EXP_W   = 7;

  // Product of count and exponent factor before saturation
  localparam int unsigned PROD_W  = CNT_W + EXP_W;

endpackage

`default_nettype wire

FILE: design/odc_div.sv
// Shared restoring divider: one quotient bit per cycle, quotient and remainder held after done.
`default_nettype none
`include "assert_macros.svh"

module odc_div #(
  parameter int unsigned WIDTH = 50
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] dividend,
  input  wire logic [WIDTH-1:0] divisor,
  output logic                  done,
  output logic [WIDTH-1:0]      quotient,
  output logic [WIDTH-1:0]      remainder
);
  import odc_pkg::*;

  localparam int unsigned STEP_W = $clog2(WIDTH + 1);

  logic [WIDTH-1:0]  num_r, num_nxt;
  logic [WIDTH-1:0]  rem_r, rem_nxt;
  logic [WIDTH-1:0]  dvs_r, dvs_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  logic [WIDTH:0]    trial;
  logic [WIDTH:0]    diff;
  logic              fits;

  // Shift in the next dividend bit and try the subtraction
  assign trial = {rem_r, num_r[WIDTH-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      // Load operands and begin a new division
      num_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      step_nxt = STEP_W'(WIDTH);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // Retire one quotient bit
      num_nxt  = {num_r[WIDTH-2:0], fits};
      rem_nxt  = fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
      step_nxt = step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = num_r;
  assign remainder = rem_r;

  `ASSERT_NEXT(a_start_busy, clk, rst_n, start, busy_r || done_r)
  `ASSERT_IMPLIES(a_done_idle, clk, rst_n, done_r, !busy_r)
  `ASSERT_IMPLIES(a_divisor_nonzero, clk, rst_n, busy_r, dvs_r != '0)

endmodule

`default_nettype wire

FILE: design/odd_divisor_counter_unit.sv
// Top level of the odd divisor counter: sequencer around the shared divider.
`default_nettype none
`include "assert_macros.svh"

// Counts the odd divisors of in_number_in (also the number of ways to write it as a sum
// of consecutive positive integers); zero gives 1. Pulse start while busy is low to hand
// in an item; busy stays high until the result appears on out_divisor_count for exactly
// one cycle with out_valid, which the receiver must take then, as it cannot stall the
// block. After the item is accepted, trailing zero bits are stripped one at a time, then
// trial divisions run in the shared restoring divider. One division runs for every
// odd candidate d = 3, 5, ... while d*d does not exceed the remaining odd part, plus one
// per prime factor found; the worst case is a large prime near 2^WIDTH. A new start is
// taken in the cycle the result is shown.
module odd_divisor_counter_unit #(
  parameter int unsigned WIDTH = 50
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [WIDTH-1:0]           in_number_in,
  output logic                            out_valid,
  output logic [odc_pkg::CNT_W-1:0]       out_divisor_count
);
  import odc_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_STRIP = 2'd1;
  localparam logic [1:0] S_DIV   = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [WIDTH-1:0] t_r, t_nxt;
  logic [WIDTH-1:0] d_r, d_nxt;
  logic [EXP_W-1:0] e_r, e_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0] out_cnt_r, out_cnt_nxt;

  logic             div_start;
  logic             div_done;
  logic [WIDTH-1:0] div_quot;
  logic [WIDTH-1:0] div_rem;

  logic [EXP_W-1:0]  factor;
  logic [PROD_W-1:0] prod;
  logic [CNT_W-1:0]  cnt_sat;

  // Shared divider: t / d for both the bound test and the remainder test
  odc_div #(
    .WIDTH (WIDTH)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (t_nxt),
    .divisor   (d_nxt),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // Count update: e+1 when closing a prime power, 2 for a leftover prime
  assign factor  = (e_r == '0) ? EXP_W'(2) : (e_r + 1'b1);
  assign prod    = PROD_W'(cnt_r) * PROD_W'(factor);
  assign cnt_sat = (prod > PROD_W'(CNT_MAX)) ? CNT_MAX : prod[CNT_W-1:0];

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    t_nxt         = t_r;
    d_nxt         = d_r;
    e_nxt         = e_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_cnt_nxt   = out_cnt_r;
    div_start     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          t_nxt     = in_number_in;
          d_nxt     = WIDTH'(3);
          e_nxt     = '0;
          cnt_nxt   = CNT_W'(1);
          state_nxt = S_STRIP;
        end
      end
      S_STRIP: begin
        if (t_r == '0) begin
          // Zero has one odd divisor by convention
          out_valid_nxt = 1'b1;
          out_cnt_nxt   = CNT_W'(1);
          state_nxt     = S_IDLE;
        end else if (!t_r[0]) begin
          t_nxt = {1'b0, t_r[WIDTH-1:1]};
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (e_r != '0) begin
            if (div_rem == '0) begin
              // Same prime divides again
              t_nxt     = div_quot;
              e_nxt     = e_r + 1'b1;
              div_start = 1'b1;
            end else begin
              // Close the prime power and move to the next candidate
              cnt_nxt   = cnt_sat;
              e_nxt     = '0;
              d_nxt     = d_r + WIDTH'(2);
              div_start = 1'b1;
            end
          end else if (d_r > div_quot) begin
            // d*d exceeds t: leftover above one is a prime
            out_valid_nxt = 1'b1;
            out_cnt_nxt   = (t_r > WIDTH'(1)) ? cnt_sat : cnt_r;
            state_nxt     = S_IDLE;
          end else if (div_rem == '0) begin
            t_nxt     = div_quot;
            e_nxt     = EXP_W'(1);
            div_start = 1'b1;
          end else begin
            d_nxt     = d_r + WIDTH'(2);
            div_start = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r       <= t_nxt;
    d_r       <= d_nxt;
    e_r       <= e_nxt;
    cnt_r     <= cnt_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_divisor_count = out_cnt_r;

  `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `ASSERT_IMPLIES(a_cand_odd, clk, rst_n, busy, d_r[0])
  `ASSERT_IMPLIES(a_result_idle, clk, rst_n, out_valid, !busy && (out_divisor_count != '0))
  `ASSERT_IMPLIES(a_div_owned, clk, rst_n, div_done, state_r == S_DIV)

endmodule

`default_nettype wire
